[sv/tsp_pkg.sv]
// Package with the types, codes and constants of the test rig sequencer.
package tsp_pkg;

    localparam int unsigned CFG_ADDR_W = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_REQUESTED_LOOP_TOTAL = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_WIDTH_MIN_US   = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_WIDTH_MAX_US   = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RESET_HOLD_SECONDS   = 8'd3;

    localparam logic [15:0] PULSE_WIDTH_MIN_RESET = 16'd990;
    localparam logic [15:0] PULSE_WIDTH_MAX_RESET = 16'd1010;
    localparam logic [3:0]  RESET_HOLD_RESET      = 4'd10;

    localparam logic [2:0] KIND_CONTROL   = 3'd0;
    localparam logic [2:0] KIND_LOOP_RISE = 3'd1;
    localparam logic [2:0] KIND_LOOP_FALL = 3'd2;
    localparam logic [2:0] KIND_TORQUE    = 3'd3;
    localparam logic [2:0] KIND_TICK      = 3'd4;

    localparam logic [1:0] HEAT_NONE    = 2'd0;
    localparam logic [1:0] HEAT_OFF     = 2'd1;
    localparam logic [1:0] HEAT_COMPUTE = 2'd2;
    localparam logic [1:0] HEAT_ARM     = 2'd3;

    localparam logic [1:0] PROG_NONE = 2'd0;
    localparam logic [1:0] PROG_RUN  = 2'd1;
    localparam logic [1:0] PROG_STOP = 2'd2;

    localparam logic [2:0] CODE_STANDBY = 3'd0;
    localparam logic [2:0] CODE_HEATING = 3'd1;
    localparam logic [2:0] CODE_RUNNING = 3'd2;
    localparam logic [2:0] CODE_PAUSED  = 3'd3;
    localparam logic [2:0] CODE_DONE    = 3'd4;
    localparam logic [2:0] CODE_RESETRQ = 3'd5;

    typedef enum logic [5:0] {
        MODE_STANDBY = 6'b000001,
        MODE_HEATING = 6'b000010,
        MODE_RUNNING = 6'b000100,
        MODE_PAUSED  = 6'b001000,
        MODE_DONE    = 6'b010000,
        MODE_RESETRQ = 6'b100000
    } mode_t;

    typedef struct packed {
        logic [31:0] requested_loop_total;
        logic [15:0] pulse_width_min_us;
        logic [15:0] pulse_width_max_us;
        logic [3:0]  reset_hold_seconds;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        run_switch;
        logic        reset_switch;
        logic        sump_below_setpoint;
        logic [31:0] time_us;
    } item_t;

    typedef struct packed {
        logic [2:0]  program_state;
        logic [1:0]  heater_command;
        logic [1:0]  program_command;
        logic        read_torque;
        logic [31:0] loop_total;
        logic [3:0]  seconds_to_reset;
        logic        test_was_reset;
    } result_t;

    function automatic logic [2:0] mode_code(input mode_t m);
        logic [2:0] code;
        case (m)
            MODE_STANDBY: code = CODE_STANDBY;
            MODE_HEATING: code = CODE_HEATING;
            MODE_RUNNING: code = CODE_RUNNING;
            MODE_PAUSED:  code = CODE_PAUSED;
            MODE_DONE:    code = CODE_DONE;
            MODE_RESETRQ: code = CODE_RESETRQ;
            default:      code = CODE_STANDBY;
        endcase
        return code;
    endfunction

endpackage

[sv/tsp_cfg.sv]
// Configuration register file of the test rig sequencer.
module tsp_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            wr_en,
    input  logic [tsp_pkg::CFG_ADDR_W-1:0]  wr_addr,
    input  logic [31:0]                     wr_data,
    output tsp_pkg::cfg_t                   cfg
);
    import tsp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.requested_loop_total <= 32'd0;
            cfg_reg.pulse_width_min_us   <= PULSE_WIDTH_MIN_RESET;
            cfg_reg.pulse_width_max_us   <= PULSE_WIDTH_MAX_RESET;
            cfg_reg.reset_hold_seconds   <= RESET_HOLD_RESET;
        end else if (wr_en) begin
            case (wr_addr)
                REG_REQUESTED_LOOP_TOTAL: cfg_reg.requested_loop_total <= wr_data;
                REG_PULSE_WIDTH_MIN_US:   cfg_reg.pulse_width_min_us   <= wr_data[15:0];
                REG_PULSE_WIDTH_MAX_US:   cfg_reg.pulse_width_max_us   <= wr_data[15:0];
                REG_RESET_HOLD_SECONDS:   cfg_reg.reset_hold_seconds   <= wr_data[3:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/tsp_core.sv]
// Sequencer state and the combinational update that one event beat applies to it.
module tsp_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  tsp_pkg::item_t    item,
    input  tsp_pkg::cfg_t     cfg,
    output tsp_pkg::result_t  result
);
    import tsp_pkg::*;

    mode_t       mode_reg, mode_next;
    logic [31:0] loop_count_reg, loop_count_next;
    logic [31:0] rise_time_reg, rise_time_next;
    logic        awaiting_fall_reg, awaiting_fall_next;
    logic        torque_pending_reg, torque_pending_next;
    logic [3:0]  countdown_reg, countdown_next;

    logic [1:0]  heater;
    logic [1:0]  prog;
    logic        torque;
    logic        was_reset;
    logic [31:0] pulse_width;
    logic        in_window;
    logic        count_reached;
    logic [3:0]  hold_start;

    assign pulse_width   = item.time_us - rise_time_reg;
    assign in_window     = (pulse_width >= {16'd0, cfg.pulse_width_min_us})
                         && (pulse_width < {16'd0, cfg.pulse_width_max_us});
    assign count_reached = loop_count_reg >= cfg.requested_loop_total;
    assign hold_start    = (cfg.reset_hold_seconds == 4'd0) ? 4'd1 : cfg.reset_hold_seconds;

    always_comb begin
        mode_next           = mode_reg;
        loop_count_next     = loop_count_reg;
        rise_time_next      = rise_time_reg;
        awaiting_fall_next  = awaiting_fall_reg;
        torque_pending_next = torque_pending_reg;
        countdown_next      = countdown_reg;
        heater              = HEAT_NONE;
        prog                = PROG_NONE;
        torque              = 1'b0;
        was_reset           = 1'b0;
        case (item.kind)
            KIND_CONTROL: begin
                case (mode_reg)
                    MODE_STANDBY: begin
                        if (item.run_switch) begin
                            mode_next = MODE_HEATING;
                        end else if (item.reset_switch) begin
                            mode_next = MODE_RESETRQ;
                        end else begin
                            heater = HEAT_OFF;
                        end
                    end
                    MODE_HEATING: begin
                        heater = HEAT_COMPUTE;
                        if (!item.run_switch) begin
                            mode_next = MODE_PAUSED;
                        end else if (item.sump_below_setpoint) begin
                            prog   = PROG_STOP;
                            heater = HEAT_ARM;
                        end else if (item.reset_switch) begin
                            mode_next = MODE_RESETRQ;
                        end else begin
                            mode_next = MODE_RUNNING;
                        end
                    end
                    MODE_RUNNING: begin
                        prog   = PROG_RUN;
                        heater = HEAT_COMPUTE;
                        if (count_reached) begin
                            mode_next = MODE_DONE;
                        end else if (torque_pending_reg) begin
                            torque_pending_next = 1'b0;
                            torque              = 1'b1;
                        end else if (item.reset_switch) begin
                            mode_next = MODE_RESETRQ;
                        end
                        if (!item.run_switch) begin
                            mode_next = MODE_PAUSED;
                        end
                    end
                    MODE_PAUSED: begin
                        prog   = PROG_STOP;
                        heater = HEAT_OFF;
                        if (item.run_switch) begin
                            mode_next = MODE_HEATING;
                        end else if (item.reset_switch) begin
                            mode_next = MODE_RESETRQ;
                        end
                    end
                    MODE_DONE: begin
                        heater = HEAT_OFF;
                        prog   = PROG_STOP;
                        if (item.reset_switch) begin
                            mode_next = MODE_RESETRQ;
                        end
                    end
                    MODE_RESETRQ: begin
                        if (!item.reset_switch) begin
                            countdown_next = 4'd0;
                            mode_next      = count_reached ? MODE_DONE : MODE_PAUSED;
                        end else begin
                            heater = HEAT_OFF;
                            prog   = PROG_STOP;
                            if (countdown_reg == 4'd0) begin
                                countdown_next = hold_start;
                            end
                        end
                    end
                    default: mode_next = MODE_STANDBY;
                endcase
            end
            KIND_LOOP_RISE: begin
                if (!awaiting_fall_reg) begin
                    rise_time_next     = item.time_us;
                    awaiting_fall_next = 1'b1;
                end
            end
            KIND_LOOP_FALL: begin
                if (awaiting_fall_reg) begin
                    if (in_window && (loop_count_reg != 32'hFFFF_FFFF)) begin
                        loop_count_next = loop_count_reg + 32'd1;
                    end
                    awaiting_fall_next = 1'b0;
                end
            end
            KIND_TORQUE: begin
                torque_pending_next = 1'b1;
            end
            KIND_TICK: begin
                if ((mode_reg == MODE_RESETRQ) && (countdown_reg != 4'd0)) begin
                    if (!item.reset_switch) begin
                        countdown_next = 4'd0;
                    end else begin
                        countdown_next = countdown_reg - 4'd1;
                        if (countdown_reg == 4'd1) begin
                            loop_count_next = 32'd0;
                            mode_next       = MODE_STANDBY;
                            was_reset       = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= MODE_STANDBY;
            loop_count_reg     <= 32'd0;
            rise_time_reg      <= 32'd0;
            awaiting_fall_reg  <= 1'b0;
            torque_pending_reg <= 1'b0;
            countdown_reg      <= 4'd0;
        end else if (step) begin
            mode_reg           <= mode_next;
            loop_count_reg     <= loop_count_next;
            rise_time_reg      <= rise_time_next;
            awaiting_fall_reg  <= awaiting_fall_next;
            torque_pending_reg <= torque_pending_next;
            countdown_reg      <= countdown_next;
        end
    end

    always_comb begin
        result.program_state    = mode_code(mode_next);
        result.heater_command   = heater;
        result.program_command  = prog;
        result.read_torque      = torque;
        result.loop_total       = loop_count_next;
        result.seconds_to_reset = countdown_next;
        result.test_was_reset   = was_reset;
    end

endmodule

[sv/test_rig_sequencer_with_pulse_counter_unit.sv]
// Top level of the test rig sequencer with loop pulse counter.
// Each accepted event beat yields exactly one result beat, in order. The block takes one beat
// per clock cycle while no result stalls: the beat is held in an input register, the
// sequencer state is updated by combinational logic, and the result lands in an output
// register. The state update sets the rate, since each beat reads the state that the one
// before it leaves. A stalled result holds the input register, so s_ready falls only while
// both registers are full. Configuration writes are taken in every cycle.
module test_rig_sequencer_with_pulse_counter_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tsp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [31:0]                     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_kind,
    input  logic                            s_run_switch,
    input  logic                            s_reset_switch,
    input  logic                            s_sump_below_setpoint,
    input  logic [31:0]                     s_time_us,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_program_state,
    output logic [1:0]                      m_heater_command,
    output logic [1:0]                      m_program_command,
    output logic                            m_read_torque,
    output logic [31:0]                     m_loop_total,
    output logic [3:0]                      m_seconds_to_reset,
    output logic                            m_test_was_reset
);
    import tsp_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result;
    result_t result_reg;
    logic    out_valid_reg;
    logic    step;

    assign cfg_ready = 1'b1;

    tsp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid),
        .wr_addr (cfg_addr),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.kind                <= s_kind;
            item_reg.run_switch          <= s_run_switch;
            item_reg.reset_switch        <= s_reset_switch;
            item_reg.sump_below_setpoint <= s_sump_below_setpoint;
            item_reg.time_us             <= s_time_us;
        end
    end

    tsp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= result;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_program_state    = result_reg.program_state;
    assign m_heater_command   = result_reg.heater_command;
    assign m_program_command  = result_reg.program_command;
    assign m_read_torque      = result_reg.read_torque;
    assign m_loop_total       = result_reg.loop_total;
    assign m_seconds_to_reset = result_reg.seconds_to_reset;
    assign m_test_was_reset   = result_reg.test_was_reset;

endmodule
